// ===== design/rpn_pkg.sv =====
// package: types, codes and constants for the rpn stack calculator
package rpn_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int CNT_W = $clog2(STACK_DEPTH + 1);

   typedef enum logic [3:0] {
      FN_PUSH = 4'd0,
      FN_READ = 4'd1,
      FN_ADD  = 4'd2,
      FN_SUB  = 4'd3,
      FN_MUL  = 4'd4,
      FN_DIV  = 4'd5,
      FN_XCHG = 4'd6,
      FN_SUM  = 4'd7,
      FN_AVG  = 4'd8
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_UNDER = 2'd1,
      ST_OVER  = 2'd2,
      ST_DIV0  = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]         func;
      logic signed [31:0] operand_value;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] top_value;
      logic [4:0]         stack_count;
   } rsp_type;

   // shift command to the row of stack cells
   typedef enum logic [1:0] {
      SH_HOLD = 2'd0,
      SH_PUSH = 2'd1,
      SH_POP  = 2'd2
   } shift_type;

   typedef struct packed {
      shift_type          shift;
      logic               ld_top;
      logic signed [31:0] top_data;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_SUM, S_DIV, S_FIN, S_RSP
   } state_type;

   // saturate a 34-bit signed value to 32 bits
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) r = 32'sh7fffffff;
      else if (v < -34'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ===== design/rpn_cell.sv =====
// one stack cell: holds an entry, shifts toward deeper neighbor on push
module rpn_cell
   import rpn_pkg::*;
(
   input  logic               clock,
   input  cell_ctl_type       ctl,
   input  logic               is_top,
   input  logic signed [31:0] upper_data,
   input  logic signed [31:0] lower_data,
   output logic signed [31:0] data
);
   logic signed [31:0] data_ff, data_in;

   // cell index 0 is top; push moves data down, pop moves data up
   always_comb begin
      data_in = data_ff;
      case (ctl.shift)
         SH_PUSH: data_in = upper_data;
         SH_POP:  data_in = lower_data;
         default: data_in = data_ff;
      endcase
      if (is_top && ctl.ld_top) data_in = ctl.top_data;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;
endmodule

// ===== design/rpn_stack_calculator.sv =====
// top level: rpn calculator with a shifting cell stack and iterative units
// push/read/add/sub/exchange, any underflow or divide by zero, and sum or
// average on at most one entry go straight to S_FIN and S_RSP; multiply passes
// S_MUL, divide S_DIV, sum S_SUM, and average S_SUM then S_DIV. the restoring
// divider makes one quotient bit per cycle, and the stack cells shift once per
// cycle during sum. one transaction at a time; the next request is taken in the
// cycle after the response is accepted. reset clears entry count and control; entries undefined.
module rpn_stack_calculator
   import rpn_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [5:0] it_ff, it_in;
   func_type fn_ff, fn_in;
   logic [1:0] status_ff, status_in;
   logic signed [31:0] acc_ff, acc_in;
   logic signed [63:0] prod_ff, prod_in;
   logic [63:0] rem_ff, rem_in, quo_ff, quo_in;
   logic [63:0] dvs_ff, dvs_in;
   logic neg_ff, neg_in;
   rsp_type rsp_ff, rsp_in;
   cell_ctl_type ctl;
   logic signed [31:0] cell_q [STACK_DEPTH];
   logic signed [31:0] top_q, sec_q;
   logic req_fire;

   // row of cells, index 0 is top
   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      logic signed [31:0] up_d, lo_d;
      if (g == 0) begin : g_t
         assign up_d = ctl.top_data;
      end else begin : g_u
         assign up_d = cell_q[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_b
         assign lo_d = cell_q[g];
      end else begin : g_l
         assign lo_d = cell_q[g+1];
      end
      rpn_cell u_cell (
         .clock(clock), .ctl(ctl), .is_top(g == 0),
         .upper_data(up_d), .lower_data(lo_d), .data(cell_q[g])
      );
   end

   assign top_q = cell_q[0];
   assign sec_q = cell_q[1];
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign rsp_valid = (state_ff == S_RSP);
   assign rsp_data = rsp_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_FIN;
               case (req_data.func)
                  FN_MUL: if (cnt_ff >= CNT_W'(2)) state_in = S_MUL;
                  FN_DIV: if (cnt_ff >= CNT_W'(2) && top_q != 0) state_in = S_DIV;
                  FN_SUM, FN_AVG: if (cnt_ff > CNT_W'(1)) state_in = S_SUM;
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_MUL: state_in = S_FIN;
         S_SUM: if (cnt_ff == CNT_W'(1))
            state_in = (fn_ff == FN_AVG) ? S_DIV : S_FIN;
         S_DIV: if (it_ff == 6'd0) state_in = S_FIN;
         S_FIN: state_in = S_RSP;
         S_RSP: if (rsp_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and cell control
   always_comb begin
      logic signed [33:0] s34;
      logic [63:0] sub;
      logic signed [63:0] qs;
      logic signed [63:0] na;
      s34 = '0;
      sub = '0;
      qs = '0;
      na = '0;
      cnt_in = cnt_ff;
      div_cnt_in = div_cnt_ff;
      it_in = it_ff;
      fn_in = fn_ff;
      status_in = status_ff;
      acc_in = acc_ff;
      prod_in = prod_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      neg_in = neg_ff;
      rsp_in = rsp_ff;
      ctl = '{shift: SH_HOLD, ld_top: 1'b0, top_data: top_q};
      case (state_ff)
         S_IDLE: if (req_fire) begin
            fn_in = func_type'(req_data.func);
            status_in = ST_OK;
            case (req_data.func)
               FN_PUSH: begin
                  if (cnt_ff >= CNT_W'(STACK_DEPTH)) status_in = ST_OVER;
                  else begin
                     ctl.shift = SH_PUSH;
                     ctl.top_data = req_data.operand_value;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
               FN_READ: if (cnt_ff == '0) status_in = ST_UNDER;
               FN_ADD, FN_SUB, FN_MUL, FN_DIV, FN_XCHG: begin
                  if (cnt_ff < CNT_W'(2)) status_in = ST_UNDER;
                  else if (req_data.func == FN_XCHG) begin
                     // drop the second entry under the top, keep it for the push back
                     ctl.shift = SH_POP;
                     ctl.ld_top = 1'b1;
                     ctl.top_data = top_q;
                     acc_in = sec_q;
                  end else if (req_data.func == FN_DIV && top_q == 0) begin
                     status_in = ST_DIV0;
                  end else if (req_data.func == FN_ADD) begin
                     s34 = 34'(sec_q) + 34'(top_q);
                     ctl.shift = SH_POP;
                     ctl.ld_top = 1'b1;
                     ctl.top_data = sat34(s34);
                     cnt_in = cnt_ff - CNT_W'(1);
                  end else if (req_data.func == FN_SUB) begin
                     s34 = 34'(sec_q) - 34'(top_q);
                     ctl.shift = SH_POP;
                     ctl.ld_top = 1'b1;
                     ctl.top_data = sat34(s34);
                     cnt_in = cnt_ff - CNT_W'(1);
                  end else if (req_data.func == FN_MUL) begin
                     prod_in = 64'(sec_q) * 64'(top_q);
                  end else begin
                     na = 64'(sec_q) <<< 16;
                     neg_in = na[63] ^ top_q[31];
                     rem_in = '0;
                     quo_in = na[63] ? 64'(-na) : 64'(na);
                     dvs_in = top_q[31] ? 64'(-64'(top_q)) : 64'(64'(top_q));
                     it_in = 6'd63;
                  end
               end
               FN_SUM, FN_AVG: begin
                  if (cnt_ff == '0) begin
                     if (req_data.func == FN_AVG) status_in = ST_UNDER;
                  end else begin
                     acc_in = top_q;
                     div_cnt_in = cnt_ff;
                  end
               end
               default: ;
            endcase
         end
         S_MUL: begin
            // arithmetic shift floors toward minus infinity
            qs = prod_ff >>> 16;
            if (qs > 64'sd2147483647) ctl.top_data = 32'sh7fffffff;
            else if (qs < -64'sd2147483648) ctl.top_data = 32'sh80000000;
            else ctl.top_data = qs[31:0];
            ctl.shift = SH_POP;
            ctl.ld_top = 1'b1;
            cnt_in = cnt_ff - CNT_W'(1);
         end
         S_SUM: begin
            // pop one entry per cycle, folding the next one into acc
            if (cnt_ff == CNT_W'(1)) begin
               ctl.ld_top = 1'b1;
               ctl.top_data = acc_ff;
               if (fn_ff == FN_AVG) begin
                  na = 64'(acc_ff);
                  neg_in = acc_ff[31];
                  rem_in = '0;
                  quo_in = na[63] ? 64'(-na) : 64'(na);
                  dvs_in = 64'(div_cnt_ff);
                  it_in = 6'd63;
               end
            end else begin
               s34 = 34'(sec_q) + 34'(acc_ff);
               acc_in = sat34(s34);
               ctl.shift = SH_POP;
               cnt_in = cnt_ff - CNT_W'(1);
            end
         end
         S_DIV: begin
            // restoring divider, one quotient bit per cycle
            sub = {rem_ff[62:0], quo_ff[63]};
            quo_in = {quo_ff[62:0], 1'b0};
            if (sub >= dvs_ff) begin
               sub = sub - dvs_ff;
               quo_in[0] = 1'b1;
            end
            rem_in = sub;
            it_in = it_ff - 6'd1;
            if (it_ff == 6'd0) begin
               qs = neg_ff ? -$signed(quo_in) : $signed(quo_in);
               if (qs > 64'sd2147483647) ctl.top_data = 32'sh7fffffff;
               else if (qs < -64'sd2147483648) ctl.top_data = 32'sh80000000;
               else ctl.top_data = qs[31:0];
               ctl.ld_top = 1'b1;
               if (fn_ff == FN_DIV) begin
                  ctl.shift = SH_POP;
                  cnt_in = cnt_ff - CNT_W'(1);
               end
            end
         end
         S_FIN: begin
            // exchange second half: old second goes back on top of old top
            if (fn_ff == FN_XCHG && status_ff == ST_OK) begin
               ctl.shift = SH_PUSH;
               ctl.top_data = acc_ff;
            end
         end
         default: ;
      endcase
      // response fields, top as it stands once this cycle's shift is done
      if (state_ff == S_FIN) begin
         rsp_in.status = status_ff;
         rsp_in.stack_count = 5'(cnt_ff);
         rsp_in.top_value = (cnt_ff == '0) ? '0 :
            ((fn_ff == FN_XCHG && status_ff == ST_OK) ? acc_ff : top_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
      end
      div_cnt_ff <= div_cnt_in;
      it_ff <= it_in;
      fn_ff <= fn_in;
      status_ff <= status_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   // assertions
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(STACK_DEPTH))
      else $error("count beyond depth");
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("ready while response pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped");
endmodule
